// ----- rtl/core/iambic_morse_keyer_unit_defines.svh -----
// assertion macros shared by the keyer rtl
`ifndef IAMBIC_MORSE_KEYER_UNIT_DEFINES_SVH
`define IAMBIC_MORSE_KEYER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define IMK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyer assertion failed");

// next-cycle implication, checked out of reset
`define IMK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyer assertion failed");

// plain invariant
`define IMK_ASSERT_ALW(label, clk, rst_n, cond) \
  `IMK_ASSERT_IMP(label, clk, rst_n, 1'b1, cond)

`else

`define IMK_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IMK_ASSERT_NXT(label, clk, rst_n, ante, cons)
`define IMK_ASSERT_ALW(label, clk, rst_n, cond)

`endif

`endif

// ----- rtl/core/imk_pkg.sv -----
// shared types and constants of the iambic keyer
package imk_pkg;

  // sequencer phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_MARK  = 2'd1;
  localparam logic [1:0] PH_SPACE = 2'd2;

  // element codes
  localparam logic [1:0] EL_NONE = 2'd0;
  localparam logic [1:0] EL_DIT  = 2'd1;
  localparam logic [1:0] EL_DAH  = 2'd2;
  localparam logic [1:0] EL_BOTH = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE_B   = 2'd0;
  localparam logic [1:0] CFG_SWAP     = 2'd1;
  localparam logic [1:0] CFG_DIT_DEF  = 2'd2;
  localparam logic [1:0] CFG_DAH_DEF  = 2'd3;

  // limits and reset values
  localparam logic [7:0] TICK_MAX    = 8'd254;
  localparam logic [3:0] RPT_MAX     = 4'd10;
  localparam logic [7:0] DAH_MIN     = 8'd30;
  localparam logic [7:0] DAH_LIMIT   = 8'd254;
  localparam logic [7:0] DIT_RESET   = 8'd72;
  localparam logic [7:0] DAH_RESET   = 8'd216;
  localparam logic [7:0] DIT_STEP    = 8'd1;
  localparam logic [7:0] DAH_STEP    = 8'd3;

  typedef struct packed {
    logic       mode_b;
    logic       swap_paddles;
    logic [7:0] default_dit_len;
    logic [7:0] default_dah_len;
  } imk_cfg_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [1:0] cur_el;
    logic [1:0] q_el;
    logic [7:0] tick;
    logic       tone;
    logic [7:0] dit_len;
    logic [7:0] dah_len;
    logic [7:0] el_len;
    logic [1:0] early;
    logic [1:0] late;
    logic [3:0] rpt;
  } imk_state_t;

  typedef struct packed {
    logic       tx_on;
    logic       sidetone;
    logic [7:0] dit_len_now;
    logic       sending;
  } imk_result_t;

  // status seen by the top level checks
  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] tick;
    logic [3:0] rpt;
  } imk_status_t;

endpackage

// ----- rtl/core/imk_in_reg.sv -----
// input register holding one paddle sample word
module imk_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] pad_in,
  input  logic       step,
  output logic       valid,
  output logic [1:0] pad
);

  logic       valid_r;
  logic       valid_nxt;
  logic [1:0] pad_r;
  logic       load;

  // free when empty or when the held word moves on this cycle
  assign in_tready = !valid_r || step;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      pad_r <= pad_in;
    end
  end

  assign valid = valid_r;
  assign pad   = pad_r;

endmodule

// ----- rtl/core/imk_core.sv -----
// keyer sequencer: state register and single-pass next-state logic
module imk_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  imk_pkg::imk_cfg_t    cfg,
  input  logic                 step,
  input  logic [1:0]           pad,
  output imk_pkg::imk_result_t result,
  output imk_pkg::imk_status_t status
);

  imk_pkg::imk_state_t st_r;
  imk_pkg::imk_state_t st_nxt;

  // queue the opposite paddle once inside the mark or space window
  function automatic imk_pkg::imk_state_t sample_mem(imk_pkg::imk_state_t s,
                                                     logic [1:0] p);
    logic [1:0] m;
    imk_pkg::imk_state_t o;
    o = s;
    m = (s.tick >= {1'b0, s.dit_len[7:1]}) ? s.late : s.early;
    if ((s.tick < s.el_len) && (s.q_el == imk_pkg::EL_NONE)) begin
      o.q_el = p & m;
    end
    return o;
  endfunction

  // begin a mark; both paddles count as a dit
  function automatic imk_pkg::imk_state_t start_el(imk_pkg::imk_state_t s,
                                                   logic [1:0] el,
                                                   logic [1:0] p,
                                                   imk_pkg::imk_cfg_t c);
    logic [1:0] e;
    logic       long_el;
    imk_pkg::imk_state_t o;
    o = s;
    e = (el == imk_pkg::EL_BOTH) ? imk_pkg::EL_DIT : el;
    long_el = (e == imk_pkg::EL_DAH) != c.swap_paddles;
    o.cur_el = e;
    o.el_len = long_el ? s.dah_len : s.dit_len;
    o.early  = imk_pkg::EL_NONE;
    o.tick   = '0;
    o.late   = imk_pkg::EL_BOTH - e;
    if (!c.mode_b && (p == imk_pkg::EL_BOTH)) begin
      o.late = imk_pkg::EL_NONE;
    end
    o.phase = imk_pkg::PH_MARK;
    return o;
  endfunction

  // speed change after a long run of equal elements
  function automatic imk_pkg::imk_state_t speed_step(imk_pkg::imk_state_t s,
                                                     imk_pkg::imk_cfg_t c);
    imk_pkg::imk_state_t o;
    o = s;
    if (s.cur_el == imk_pkg::EL_DIT) begin
      o.dit_len = s.dit_len - imk_pkg::DIT_STEP;
      o.dah_len = s.dah_len - imk_pkg::DAH_STEP;
    end else begin
      o.dit_len = s.dit_len + imk_pkg::DIT_STEP;
      o.dah_len = s.dah_len + imk_pkg::DAH_STEP;
    end
    if ((o.dah_len < imk_pkg::DAH_MIN) || (o.dah_len >= imk_pkg::DAH_LIMIT)) begin
      o.dit_len = c.default_dit_len;
      o.dah_len = c.default_dah_len;
    end
    return o;
  endfunction

  // one tick: tone, counter, idle start, mark end, space end
  always_comb begin
    logic [1:0] nxt_el;
    imk_pkg::imk_state_t s;
    s = st_r;
    s.tone = ~st_r.tone;
    if (s.tick != imk_pkg::TICK_MAX) begin
      s.tick = s.tick + {7'd0, s.tone};
    end

    if ((s.phase == imk_pkg::PH_IDLE) && (pad != imk_pkg::EL_NONE)) begin
      s = start_el(s, pad, pad, cfg);
    end

    if (s.phase == imk_pkg::PH_MARK) begin
      if (s.tick < s.el_len) begin
        s = sample_mem(s, pad);
      end else begin
        s.tick   = '0;
        s.el_len = s.dit_len;
        s.early  = s.late;
        s.phase  = imk_pkg::PH_SPACE;
      end
    end

    nxt_el = imk_pkg::EL_NONE;
    if (s.phase == imk_pkg::PH_SPACE) begin
      if (s.tick < s.el_len) begin
        s = sample_mem(s, pad);
      end else begin
        nxt_el = (s.q_el == imk_pkg::EL_NONE) ? pad : s.q_el;
        if (nxt_el == imk_pkg::EL_BOTH) begin
          nxt_el = imk_pkg::EL_BOTH - s.cur_el;
        end
        if (nxt_el == s.cur_el) begin
          if (s.rpt < imk_pkg::RPT_MAX) begin
            s.rpt = s.rpt + 4'd1;
          end
        end else begin
          s.rpt = '0;
        end
        if (s.rpt >= imk_pkg::RPT_MAX) begin
          s = speed_step(s, cfg);
        end
        s.q_el   = imk_pkg::EL_NONE;
        s.cur_el = nxt_el;
        if (nxt_el != imk_pkg::EL_NONE) begin
          s = start_el(s, nxt_el, pad, cfg);
          s = sample_mem(s, pad);
        end else begin
          s.phase = imk_pkg::PH_IDLE;
        end
      end
    end
    st_nxt = s;
  end

  // state register, advanced once per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase   <= imk_pkg::PH_IDLE;
      st_r.cur_el  <= imk_pkg::EL_NONE;
      st_r.q_el    <= imk_pkg::EL_NONE;
      st_r.tick    <= '0;
      st_r.tone    <= 1'b0;
      st_r.dit_len <= imk_pkg::DIT_RESET;
      st_r.dah_len <= imk_pkg::DAH_RESET;
      st_r.el_len  <= '0;
      st_r.early   <= imk_pkg::EL_NONE;
      st_r.late    <= imk_pkg::EL_NONE;
      st_r.rpt     <= '0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

  // result from the state after this tick
  always_comb begin
    result.tx_on       = (st_nxt.phase == imk_pkg::PH_MARK);
    result.sidetone    = (st_nxt.phase == imk_pkg::PH_MARK) && st_nxt.tone;
    result.dit_len_now = st_nxt.dit_len;
    result.sending     = (st_nxt.phase != imk_pkg::PH_IDLE);
  end

  assign status.phase = st_r.phase;
  assign status.tick  = st_r.tick;
  assign status.rpt   = st_r.rpt;

endmodule

// ----- rtl/core/imk_out_reg.sv -----
// result register on the output side
module imk_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  imk_pkg::imk_result_t result,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic                 can_load,
  output logic [15:0]          out_tdata
);

  logic                 valid_r;
  logic                 valid_nxt;
  imk_pkg::imk_result_t res_r;

  assign can_load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {5'd0, res_r.sending, res_r.dit_len_now, res_r.sidetone, res_r.tx_on};

endmodule

// ----- rtl/core/iambic_morse_keyer_unit.sv -----
// top level of the iambic paddle keyer
//
//   channel | direction | word contents
//   --------+-----------+--------------------------------------------------
//   in_     | sink      | one tick: dit and dah contact samples
//   out_    | source    | one result per tick: tx, sidetone, dit length, busy
//   cfg_    | write     | mode, swap, default dit and dah lengths
//
// one word per clock sustained while out_tready stays high; a word's result is offered
// once it has gone through the input register, then the sequencer pass into the result register.
// rst_n is synchronous and clears the sequencer to idle with reset lengths
// and the configuration to its reset values.
// when the result register is full and not taken, the input register keeps
// its word and in_tready drops once it is full; nothing is dropped or repeated.
`include "iambic_morse_keyer_unit_defines.svh"

module iambic_morse_keyer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] dit_contact, [1] dah_contact, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] tx_on, [1] sidetone, [9:2] dit_len_now,
                                  // [10] sending, rest zero
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  imk_pkg::imk_cfg_t    cfg_r;
  imk_pkg::imk_result_t result;
  imk_pkg::imk_status_t status;
  logic                 in_valid;
  logic [1:0]           pad;
  logic                 out_can;
  logic                 step;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_b          <= 1'b0;
      cfg_r.swap_paddles    <= 1'b0;
      cfg_r.default_dit_len <= imk_pkg::DIT_RESET;
      cfg_r.default_dah_len <= imk_pkg::DAH_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        imk_pkg::CFG_MODE_B:  cfg_r.mode_b          <= cfg_wdata[0];
        imk_pkg::CFG_SWAP:    cfg_r.swap_paddles    <= cfg_wdata[0];
        imk_pkg::CFG_DIT_DEF: cfg_r.default_dit_len <= cfg_wdata;
        imk_pkg::CFG_DAH_DEF: cfg_r.default_dah_len <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a held word moves through the sequencer when the result slot is free
  assign step = in_valid && out_can;

  imk_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .pad_in    (in_tdata[1:0]),
    .step      (step),
    .valid     (in_valid),
    .pad       (pad)
  );

  imk_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .step   (step),
    .pad    (pad),
    .result (result),
    .status (status)
  );

  imk_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .result     (result),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .can_load   (out_can),
    .out_tdata  (out_tdata)
  );

  // checks
  `IMK_ASSERT_ALW(a_tick_sat, clk, rst_n, status.tick <= imk_pkg::TICK_MAX)
  `IMK_ASSERT_ALW(a_rpt_sat, clk, rst_n, status.rpt <= imk_pkg::RPT_MAX)
  `IMK_ASSERT_IMP(a_out_cons, clk, rst_n, out_tvalid, (!out_tdata[0] || out_tdata[10]) && (!out_tdata[1] || out_tdata[0]))
  `IMK_ASSERT_NXT(a_hold_state, clk, rst_n, !step, $stable(status))

endmodule
